@@ hdl/hfss_pkg.sv @@
// shared constants, types and saturation helpers for the ftcs heat solver
package hfss_pkg;

  // grid and number format
  localparam int MAX_POINTS = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MIN_LEN    = 3;

  // port field widths
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int BETA_W     = 16;
  localparam int STEPS_W    = 16;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_TDATA_W = ((IDX_W + OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - OUT_W;

  // datapath widths
  localparam int LAP_W  = VALUE_BITS + 2;
  localparam int MAG_W  = VALUE_BITS + 1;
  localparam int PROD_W = MAG_W + BETA_W;
  localparam int DMAG_W = PROD_W - BETA_W;
  localparam int SUM_W  = VALUE_BITS + 3;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (BETA_W - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BETA   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEPS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POINTS = CFG_IDX_W'(2);

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]             idx_t;

  // clamp a wide signed value to the stored value range
  function automatic val_t sat_val(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return VALUE_BITS'(hi);
    if (v < lo) return VALUE_BITS'(lo);
    return VALUE_BITS'(v);
  endfunction

  // clamp a wide signed value to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return OUT_W'(hi);
    if (v < lo) return OUT_W'(lo);
    return OUT_W'(v);
  endfunction

endpackage

@@ hdl/heat_ftcs_stencil_solver_top.sv @@
// 1d explicit ftcs heat solver: row buffers, pipelined stencil unit and sequencer
// Loading accepts an item whenever s_axis_tvalid is high; the row completes on the
// item that fills the row length (points_in_use clamped to MIN_LEN..MAX_POINTS).
// Then each time step is one sweep of the shared stencil pipeline over the row plus
// its drain, for num_steps steps; the row is then read out and emitted point by point.
// New items are taken only while loading. Reset (rst_ni low, async) clears control
// registers and loads the config defaults; row buffers are not cleared.
module heat_ftcs_stencil_solver_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hfss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hfss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hfss_pkg::IN_W-1:0]           s_axis_tdata,  // initial_value
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [hfss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // point_index, final_value, pad
  output logic                                m_axis_tlast
);
  import hfss_pkg::*;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_OUT_RD = 3'd3;
  localparam logic [2:0] ST_OUT_LD = 3'd4;

  // control state
  logic [2:0]          state_q, state_d;
  idx_t                idx_q, idx_d;
  logic [CNT_W-1:0]    load_cnt_q, load_cnt_d;
  logic [STEPS_W-1:0]  step_q, step_d;
  logic                cur_q, cur_d;
  logic                m_valid_q, m_valid_d;
  logic                m_load;

  // configuration registers
  logic [BETA_W-1:0]   beta_q;
  logic [STEPS_W-1:0]  num_steps_q;
  logic [LEN_W-1:0]    points_q;

  // row buffers
  val_t                mem_a [MAX_POINTS];
  val_t                mem_b [MAX_POINTS];
  val_t                rdata_a_q, rdata_b_q;
  logic                we_a, we_b;
  idx_t                waddr;
  val_t                wdata;
  logic                load_we;

  // stencil pipeline
  logic                rv_q, wv_q, a_v_q, b_v_q, c_v_q, d_v_q;
  idx_t                rk_q, wk_q, a_k_q, b_k_q, c_k_q, d_k_q;
  val_t                left_q, cen_q, right_q;
  logic signed [LAP_W-1:0]  a_lap_q;
  val_t                a_u_q, b_u_q, c_u_q, d_u_q;
  logic [MAG_W-1:0]    b_mag_q;
  logic                b_neg_q, c_neg_q;
  logic [PROD_W-1:0]   c_prod_q;
  logic [DMAG_W-1:0]   d_dmag;
  logic signed [SUM_W-1:0]  d_delta_q, d_delta;
  logic signed [SUM_W-1:0]  e_sum;
  val_t                e_val;
  logic                pipe_busy;

  // output register
  idx_t                      m_idx_q;
  logic signed [OUT_W-1:0]   m_val_q;
  logic                      m_last_q;

  // derived values
  logic [CNT_W-1:0]    n_len;
  idx_t                last_idx;
  val_t                in_val;
  val_t                rd_val, sw_val, out_val;

  // row length clamp
  always_comb begin
    n_len = points_q;
    if (points_q < LEN_W'(MIN_LEN)) n_len = CNT_W'(MIN_LEN);
    if (points_q > LEN_W'(MAX_POINTS)) n_len = CNT_W'(MAX_POINTS);
  end
  assign last_idx = IDX_W'(n_len - CNT_W'(1));

  assign in_val = sat_val(64'(signed'(s_axis_tdata)));

  // read data select, end points always read as zero
  assign rd_val  = cur_q ? rdata_b_q : rdata_a_q;
  assign sw_val  = (rk_q == '0 || rk_q == last_idx) ? '0 : rd_val;
  assign out_val = (idx_q == '0 || idx_q == last_idx) ? '0 : rd_val;

  // config port
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q      <= BETA_W'(26561);
      num_steps_q <= STEPS_W'(400);
      points_q    <= LEN_W'(64);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BETA:   beta_q      <= cfg_data_i[BETA_W-1:0];
        REG_STEPS:  num_steps_q <= cfg_data_i[STEPS_W-1:0];
        REG_POINTS: points_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // buffer write port: load writes the current row, sweep writes the other one
  assign s_axis_tready = (state_q == ST_LOAD);
  assign load_we = s_axis_tvalid && s_axis_tready && (load_cnt_q < CNT_W'(MAX_POINTS));
  assign waddr   = d_v_q ? d_k_q : load_cnt_q[IDX_W-1:0];
  assign wdata   = d_v_q ? e_val : in_val;
  assign we_a    = (load_we && !cur_q) || (d_v_q && cur_q);
  assign we_b    = (load_we && cur_q) || (d_v_q && !cur_q);

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[waddr] <= wdata;
    rdata_a_q <= mem_a[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[waddr] <= wdata;
    rdata_b_q <= mem_b[idx_q];
  end

  // rounding and update arithmetic
  assign d_dmag  = DMAG_W'((c_prod_q + ROUND_HALF) >> BETA_W);
  assign d_delta = c_neg_q ? -signed'(SUM_W'(d_dmag)) : signed'(SUM_W'(d_dmag));
  assign e_sum   = SUM_W'(d_u_q) + d_delta_q;
  assign e_val   = sat_val(64'(e_sum));

  assign pipe_busy = rv_q || wv_q || a_v_q || b_v_q || c_v_q || d_v_q;

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q  <= 1'b0;
      wv_q  <= 1'b0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      rv_q  <= (state_q == ST_SWEEP);
      wv_q  <= rv_q && (rk_q >= IDX_W'(2));
      a_v_q <= wv_q;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  // pipeline payload: window, laplacian, magnitude, product, delta
  always_ff @(posedge clk_i) begin
    rk_q <= idx_q;
    if (rv_q) begin
      left_q  <= cen_q;
      cen_q   <= right_q;
      right_q <= sw_val;
    end
    wk_q    <= rk_q - IDX_W'(1);
    a_lap_q <= LAP_W'(right_q) + LAP_W'(left_q) - (LAP_W'(cen_q) <<< 1);
    a_u_q   <= cen_q;
    a_k_q   <= wk_q;
    b_neg_q <= a_lap_q[LAP_W-1];
    b_mag_q <= MAG_W'(a_lap_q[LAP_W-1] ? -a_lap_q : a_lap_q);
    b_u_q   <= a_u_q;
    b_k_q   <= a_k_q;
    c_prod_q <= PROD_W'(b_mag_q) * PROD_W'(beta_q);
    c_neg_q  <= b_neg_q;
    c_u_q    <= b_u_q;
    c_k_q    <= b_k_q;
    d_delta_q <= d_delta;
    d_u_q     <= c_u_q;
    d_k_q     <= c_k_q;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    load_cnt_d = load_cnt_q;
    step_d     = step_q;
    cur_d      = cur_q;
    m_valid_d  = m_valid_q;
    m_load     = 1'b0;
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (s_axis_tvalid) begin
          if (CNT_W'(load_cnt_q + CNT_W'(1)) >= n_len) begin
            load_cnt_d = '0;
            idx_d      = '0;
            step_d     = '0;
            state_d    = (num_steps_q == '0) ? ST_OUT_RD : ST_SWEEP;
          end else begin
            load_cnt_d = CNT_W'(load_cnt_q + CNT_W'(1));
          end
        end
      end
      ST_SWEEP: begin
        idx_d = IDX_W'(idx_q + IDX_W'(1));
        if (idx_q == last_idx) begin
          idx_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // swap rows once every update of this step is written
        if (!pipe_busy) begin
          cur_d   = !cur_q;
          step_d  = STEPS_W'(step_q + STEPS_W'(1));
          state_d = (STEPS_W'(step_q + STEPS_W'(1)) == num_steps_q) ? ST_OUT_RD : ST_SWEEP;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load    = 1'b1;
          m_valid_d = 1'b1;
          if (idx_q == last_idx) begin
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = IDX_W'(idx_q + IDX_W'(1));
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      idx_q      <= '0;
      load_cnt_q <= '0;
      step_q     <= '0;
      cur_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      load_cnt_q <= load_cnt_d;
      step_q     <= step_d;
      cur_q      <= cur_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // output item register
  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_idx_q  <= idx_q;
      m_val_q  <= sat_out(64'(out_val));
      m_last_q <= (idx_q == last_idx);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {OUT_PAD_W'(0), m_val_q, m_idx_q};
  assign m_axis_tlast  = m_last_q;

endmodule

@@ sim/tb_heat_ftcs_stencil_solver_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the ftcs heat solver: row loading, time stepping and row output

// tracks the loaded row and registers, steps the row and checks each emitted point
class ftcs_row_tracker;
  typedef struct {
    hfss_pkg::idx_t point_index;
    hfss_pkg::val_t final_value;
    logic           last_point;
  } grid_point_t;

  int unsigned beta_q16;
  int unsigned num_steps;
  int unsigned points_in_use;
  int unsigned load_count;
  int unsigned errors;
  longint      grid [hfss_pkg::MAX_POINTS];
  grid_point_t final_row_q [$];

  function new();
    beta_q16      = 26561;
    num_steps     = 400;
    points_in_use = 64;
    load_count    = 0;
    errors        = 0;
  endfunction

  // clamp to a signed range of the given width
  function longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // beta * lap / 2^16, magnitude rounded half away from zero
  function longint diffusion_delta(longint lap);
    longint unsigned mag;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned res;
    longint unsigned b;
    bit              neg;
    b   = 64'(beta_q16);
    neg = (lap < 0);
    mag = neg ? -lap : lap;
    quo = mag >> 16;
    rem = mag & 64'hFFFF;
    res = quo * b + ((rem * b + 64'h8000) >> 16);
    return neg ? -longint'(res) : longint'(res);
  endfunction

  // effective row length after clamping
  function int unsigned row_len();
    int unsigned n;
    n = points_in_use;
    if (n < hfss_pkg::MIN_LEN) n = hfss_pkg::MIN_LEN;
    if (n > hfss_pkg::MAX_POINTS) n = hfss_pkg::MAX_POINTS;
    return n;
  endfunction

  function void set_reg(logic [hfss_pkg::CFG_IDX_W-1:0] idx,
                        logic [hfss_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      hfss_pkg::REG_BETA:   beta_q16      = 32'(data);
      hfss_pkg::REG_STEPS:  num_steps     = 32'(data);
      hfss_pkg::REG_POINTS: points_in_use = 32'(data & 16'h007F);
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return final_row_q.size();
  endfunction

  // store one accepted item; on row completion step the row and queue its points
  function void note_input(logic [hfss_pkg::IN_W-1:0] raw);
    int unsigned n;
    longint      lap;
    longint      next_row [hfss_pkg::MAX_POINTS];
    grid_point_t pt;
    n = row_len();
    if (load_count < hfss_pkg::MAX_POINTS)
      grid[load_count] = clamp(longint'($signed(raw)), hfss_pkg::VALUE_BITS);
    load_count = (load_count + 1) & 32'h7F;
    if (load_count < n) return;

    // ends pinned at zero, interior advanced from the previous row
    grid[0]     = 0;
    grid[n - 1] = 0;
    for (int unsigned s = 0; s < num_steps; s++) begin
      for (int unsigned j = 1; j + 1 < n; j++) begin
        lap         = grid[j + 1] - 2 * grid[j] + grid[j - 1];
        next_row[j] = clamp(grid[j] + diffusion_delta(lap), hfss_pkg::VALUE_BITS);
      end
      for (int unsigned j = 1; j + 1 < n; j++) grid[j] = next_row[j];
    end

    for (int unsigned j = 0; j < n; j++) begin
      pt.point_index = hfss_pkg::idx_t'(j);
      pt.final_value = hfss_pkg::val_t'(clamp(grid[j], hfss_pkg::OUT_W));
      pt.last_point  = (j + 1 == n);
      final_row_q.push_back(pt);
    end
    load_count = 0;
  endfunction

  function void check_result(hfss_pkg::idx_t idx, hfss_pkg::val_t value, logic last);
    grid_point_t want;
    if (final_row_q.size() == 0) begin
      $error("unexpected item: point_index %0d final_value %0d last_point %0b",
             idx, value, last);
      errors++;
      return;
    end
    want = final_row_q.pop_front();
    if (idx !== want.point_index) begin
      $error("point_index: expected %0d, got %0d", want.point_index, idx);
      errors++;
    end
    if (value !== want.final_value) begin
      $error("final_value: expected %0d, got %0d", want.final_value, value);
      errors++;
    end
    if (last !== want.last_point) begin
      $error("last_point: expected %0b, got %0b", want.last_point, last);
      errors++;
    end
  endfunction
endclass

module tb_heat_ftcs_stencil_solver_top;
  import hfss_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int CFG_SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES      = 50;
  localparam int HOLD_OFF_CYCLES   = 600;
  localparam int ITEM_TARGET       = 230;
  localparam logic [IN_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [IN_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [IN_W-1:0] Q30_ONE   = 32'h4000_0000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_W-1:0]        s_axis_tdata  = '0;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_ready_o;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;

  ftcs_row_tracker rows = new();

  heat_ftcs_stencil_solver_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // random initial value biased toward extremes and the q1.30 unit range
  function automatic logic [IN_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return IN_W'($urandom_range(0, 2048)) - IN_W'(1024);
      4:       return IN_W'($urandom_range(0, 32'h8000_0000)) - Q30_ONE;
      default: return $urandom;
    endcase
  endfunction

  // register write once the block has drained; input valid is dropped first
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (rows.pending() != 0) @(negedge clk_i);
    repeat (CFG_SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    rows.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] beta, input logic [CFG_DATA_W-1:0] steps,
                           input logic [CFG_DATA_W-1:0] points);
    write_reg(REG_BETA, beta);
    write_reg(REG_STEPS, steps);
    write_reg(REG_POINTS, points);
  endtask

  // offer one item, with random idle cycles ahead of it
  task automatic send_value(input logic [IN_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    rows.note_input(v);
    items_sent++;
    @(negedge clk_i);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // check every accepted output item
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      rows.check_result(m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: OUT_W], m_axis_tlast);
  end

  // stimulus
  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned row_count;
    int unsigned extra;
    logic [CFG_DATA_W-1:0] beta;
    logic [CFG_DATA_W-1:0] steps;
    logic [CFG_DATA_W-1:0] points;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero steps: only the ends are cleared
    configure(16'd32768, 16'd0, 16'd3);
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value(32'h0000_0001);

    // length below minimum acts as three, zero beta leaves the interior alone
    configure(16'd0, 16'd1, 16'd0);
    send_value(VALUE_MIN);
    send_value(VALUE_MAX);
    send_value('1);

    // beta above one half on alternating extremes saturates; upper data bits ignored
    configure(16'hFFFF, 16'd3, 16'hFF85);
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value(VALUE_MAX);

    // longest step count on the shortest row
    configure(16'd32768, 16'hFFFF, 16'd2);
    send_value('0);
    send_value(Q30_ONE);
    send_value('0);

    // unused register index, then a row shortened while it is loading
    write_reg(REG_UNUSED, 16'hFFFF);
    configure(16'd16384, 16'd2, 16'd10);
    repeat (5) send_value(rand_value());
    write_reg(REG_POINTS, 16'd4);
    send_value(rand_value());

    // receiver holds off while the next row keeps being offered
    configure(16'd26561, 16'd5, 16'd8);
    hold_request = HOLD_OFF_CYCLES;
    repeat (24) send_value(rand_value());

    // full-length row, length above maximum acts as maximum
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    configure(16'd26561, 16'd400, 16'd127);
    repeat (64) send_value(rand_value());

    // random phases cycling through the idle patterns
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      case ($urandom_range(0, 7))
        0:       beta = '0;
        1:       beta = 16'd32768;
        2:       beta = CFG_DATA_W'($urandom_range(32769, 65535));
        default: beta = CFG_DATA_W'($urandom_range(1, 32767));
      endcase
      case ($urandom_range(0, 7))
        0:       steps = '0;
        1:       steps = CFG_DATA_W'($urandom_range(100, 300));
        default: steps = CFG_DATA_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0:       points = CFG_DATA_W'($urandom_range(0, 2));
        1:       points = CFG_DATA_W'($urandom_range(13, 40));
        2:       points = CFG_DATA_W'($urandom);
        default: points = CFG_DATA_W'($urandom_range(3, 12));
      endcase
      configure(beta, steps, points);
      n         = rows.row_len();
      row_count = (n > 16) ? 1 : $urandom_range(1, 3);
      // sometimes leave a partial row to be finished under the next setting
      extra     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : 0;
      repeat (row_count * n + extra) send_value(rand_value());
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (rows.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (rows.errors == 0)
      $display("heat_ftcs_stencil_solver_top test passed");
    else
      $display("heat_ftcs_stencil_solver_top test failed");
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("heat_ftcs_stencil_solver_top test failed");
    $finish;
  end

endmodule
